>>> hw/rtl/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg - shared types and constants of the weighted 5x5 mean filter
// Window geometry, weight table, divider constants and the control struct
// that travels down the pipeline.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int WIN       = 5;
  localparam int HALF      = 2;
  localparam int LINES     = 4;
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int MIN_DIM   = 3;
  localparam int RESET_DIM = 512;

  // 13 bits: heaviest column is 22 * 255; 15 bits: full sum is 74 * 255
  localparam int PART_W = 13;
  localparam int SUM_W  = 15;

  // floor(s / 74) == (s * 14170) >> 20 for every s up to 74 * 255
  localparam int WEIGHT_SUM = 74;
  localparam int DIV_SHIFT  = 20;
  localparam int DIV_MULT_W = 14;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 14'd14170;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef logic [PIX_W-1:0]                  pixel_t;
  typedef logic [WIN-1:0][PIX_W-1:0]         column_t;
  typedef logic [LINES-1:0][PIX_W-1:0]       line_word_t;
  typedef logic [WIN-1:0][PART_W-1:0]        partials_t;

  // weight[row][column]
  localparam logic [2:0] WEIGHTS [WIN][WIN] = '{
    '{3'd1, 3'd2, 3'd3, 3'd2, 3'd1},
    '{3'd2, 3'd4, 3'd5, 3'd4, 3'd2},
    '{3'd3, 3'd5, 3'd6, 3'd5, 3'd3},
    '{3'd2, 3'd4, 3'd5, 3'd4, 3'd2},
    '{3'd1, 3'd2, 3'd3, 3'd2, 3'd1}
  };

  typedef struct packed {
    logic           emit;      // this transaction produces an output pixel
    logic           last;      // output pixel closes the frame
    logic [WIN-1:0] col_mask;  // window column lies inside the frame
    logic [WIN-1:0] row_mask;  // window row lies inside the frame
  } item_ctrl_t;

endpackage

>>> hw/rtl/wmf_in_if.sv
// ----------------------------------------------------------------------------
// wmf_in_if - input pixel channel
// Valid/ready channel carrying opcode and pixel.
// ----------------------------------------------------------------------------
interface wmf_in_if import wmf_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  pixel_t pixel;

  modport source (output valid, output opcode, output pixel, input ready);
  modport sink   (input valid, input opcode, input pixel, output ready);
endinterface

>>> hw/rtl/wmf_out_if.sv
// ----------------------------------------------------------------------------
// wmf_out_if - filtered pixel channel
// Valid/ready channel carrying the filtered pixel and the end-of-frame flag.
// ----------------------------------------------------------------------------
interface wmf_out_if import wmf_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t filtered;
  logic   last_of_frame;

  modport source (output valid, output filtered, output last_of_frame, input ready);
  modport sink   (input valid, input filtered, input last_of_frame, output ready);
endinterface

>>> hw/rtl/weighted_mean_filter_5x5_unit.sv
// ----------------------------------------------------------------------------
// weighted_mean_filter_5x5_unit - weighted 5x5 mean filter, zero padded
// Output: the input transaction that completes a window (2 rows + 2 pixels
//   later in raster) reaches the output through the s1, s2, s3, s4 and out registers.
// Throughput: one transaction per cycle while the output is not stalled; one
//   line store read and one write per cycle sets it.
// Reset: rst_n (sync, low) clears counters, window, pipeline valids and sets
//   both frame sizes to 512; line store contents stay undefined (no sweep).
// ----------------------------------------------------------------------------
module weighted_mean_filter_5x5_unit import wmf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  wmf_in_if.sink               in_ch,
  wmf_out_if.source            out_ch
);

  localparam int AW = $clog2(MAX_WIDTH);

  // Pipeline (all stages advance together when the output slot frees up):
  //   accept : counters update, edge masks built, line store read issued
  //   s1     : line store data back; column written back one line up,
  //            window shifts in the new column
  //   s2     : window holds the item's 5x5 neighborhood
  //   s3     : five masked weighted column sums
  //   s4     : full weighted sum
  //   out    : floor(sum / 74) by reciprocal multiply, held for the sink
  logic             adv;
  logic             accept;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  line_word_t       rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  line_word_t       wr_data;
  logic             s1_valid;
  pixel_t           s1_pixel;
  logic [AW-1:0]    s1_addr;
  item_ctrl_t       s1_ctrl;
  logic             s3_valid;
  logic             s3_last;
  partials_t        s3_part;

  // output register drained or empty: whole pipe may move
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  wmf_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .adv        (adv),
    .accept     (accept),
    .opcode     (in_ch.opcode),
    .pixel      (in_ch.pixel),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .s1_valid_r (s1_valid),
    .s1_pixel_r (s1_pixel),
    .s1_addr_r  (s1_addr),
    .s1_ctrl_r  (s1_ctrl)
  );

  // four line stores side by side: one word per column, line 0 oldest
  wmf_ram #(
    .WIDTH (LINES * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  wmf_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .adv        (adv),
    .s1_valid   (s1_valid),
    .s1_pixel   (s1_pixel),
    .s1_addr    (s1_addr),
    .s1_ctrl    (s1_ctrl),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .s3_valid_r (s3_valid),
    .s3_last_r  (s3_last),
    .s3_part_r  (s3_part)
  );

  wmf_mean u_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s3_valid (s3_valid),
    .s3_last  (s3_last),
    .s3_part  (s3_part),
    .out_ch   (out_ch)
  );

endmodule

>>> hw/rtl/wmf_ram.sv
// ----------------------------------------------------------------------------
// wmf_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/wmf_ctrl.sv
// ----------------------------------------------------------------------------
// wmf_ctrl - frame position tracking and edge masks
// Holds the frame size registers and the input/output raster counters,
// launches the line store read and builds the per-transaction control word.
// ----------------------------------------------------------------------------
module wmf_ctrl import wmf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         adv,
  input  logic                         accept,
  input  logic                         opcode,
  input  pixel_t                       pixel,
  output logic                         rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic                         s1_valid_r,
  output pixel_t                       s1_pixel_r,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_addr_r,
  output item_ctrl_t                   s1_ctrl_r
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 3);   // input row runs to height + 2
  localparam int CXW = CW + 1;
  localparam int RXW = RW + 1;
  localparam int DWW = (CW > CFG_W) ? CW : CFG_W;
  localparam int DHW = (RW > CFG_W) ? RW : CFG_W;
  localparam int RST_W = (RESET_DIM > MAX_WIDTH)  ? MAX_WIDTH  : RESET_DIM;
  localparam int RST_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

  logic [CW-1:0] width_r,  width_nxt;
  logic [RW-1:0] height_r, height_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  logic          frame_in_done;
  logic          active;
  logic          emit;
  logic          last;
  logic [CW-1:0] in_col_inc;
  logic [CW-1:0] out_col_inc;
  logic [RW-1:0] out_row_inc;
  logic [DWW-1:0] wval;
  logic [DHW-1:0] hval;
  logic [WIN-1:0] col_mask, row_mask;

  // clamp written sizes to the supported range
  always_comb begin
    wval = DWW'(cfg_wdata);
    hval = DHW'(cfg_wdata);
    if (wval < DWW'(MIN_DIM)) begin
      width_nxt = CW'(MIN_DIM);
    end else if (wval > DWW'(MAX_WIDTH)) begin
      width_nxt = CW'(MAX_WIDTH);
    end else begin
      width_nxt = CW'(wval);
    end
    if (hval < DHW'(MIN_DIM)) begin
      height_nxt = RW'(MIN_DIM);
    end else if (hval > DHW'(MAX_HEIGHT)) begin
      height_nxt = RW'(MAX_HEIGHT);
    end else begin
      height_nxt = RW'(hval);
    end
  end

  // once all rows are in, every transaction flushes with a zero pixel
  assign frame_in_done = (in_row_r >= height_r);
  assign active        = frame_in_done || (opcode_t'(opcode) == OP_PIXEL);
  assign emit          = (in_row_r > RW'(HALF)) ||
                         ((in_row_r == RW'(HALF)) && (in_col_r >= CW'(HALF)));
  assign in_col_inc    = in_col_r + CW'(1);
  assign out_col_inc   = out_col_r + CW'(1);
  assign out_row_inc   = out_row_r + RW'(1);
  assign last          = (out_row_inc >= height_r) && (out_col_inc >= width_r);

  always_comb begin
    logic [CXW-1:0] c;
    logic [RXW-1:0] r;
    for (int k = 0; k < WIN; k++) begin
      c = CXW'(out_col_r) + CXW'(k);
      r = RXW'(out_row_r) + RXW'(k);
      col_mask[k] = (c >= CXW'(HALF)) && ((c - CXW'(HALF)) < CXW'(width_r));
      row_mask[k] = (r >= RXW'(HALF)) && ((r - RXW'(HALF)) < RXW'(height_r));
    end
  end

  always_comb begin
    in_col_nxt  = in_col_inc;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (in_col_inc >= width_r) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + RW'(1);
    end
    if (emit) begin
      if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (out_col_inc >= width_r) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_inc;
      end else begin
        out_col_nxt = out_col_inc;
      end
    end
  end

  assign rd_en   = accept && active;
  assign rd_addr = in_col_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= CW'(RST_W);
      height_r  <= RW'(RST_H);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  width_r  <= width_nxt;
        REG_FRAME_HEIGHT: height_r <= height_nxt;
        default: ;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (accept && active) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept && active;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      s1_pixel_r         <= frame_in_done ? '0 : pixel;
      s1_addr_r          <= in_col_r[AW-1:0];
      s1_ctrl_r.emit     <= emit;
      s1_ctrl_r.last     <= emit && last;
      s1_ctrl_r.col_mask <= col_mask;
      s1_ctrl_r.row_mask <= row_mask;
    end
  end

endmodule

>>> hw/rtl/wmf_window.sv
// ----------------------------------------------------------------------------
// wmf_window - 5x5 window and masked column sums
// Joins the line store column with the new pixel, writes the column back
// shifted by one line, shifts the window and forms five weighted column sums.
// ----------------------------------------------------------------------------
module wmf_window import wmf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic                         adv,
  input  logic                         s1_valid,
  input  pixel_t                       s1_pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  input  item_ctrl_t                   s1_ctrl,
  input  line_word_t                   rd_data,
  output logic                         wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output line_word_t                   wr_data,
  output logic                         s3_valid_r,
  output logic                         s3_last_r,
  output partials_t                    s3_part_r
);

  column_t    col;
  column_t    window_r [WIN];   // oldest column first, row 0 on top
  logic       s2_valid_r;
  item_ctrl_t s2_ctrl_r;
  partials_t  part;

  always_comb begin
    for (int j = 0; j < LINES; j++) begin
      col[j] = rd_data[j];
    end
    col[WIN-1] = s1_pixel;
    for (int j = 0; j < LINES; j++) begin
      wr_data[j] = col[j+1];
    end
  end

  assign wr_en   = adv && s1_valid;
  assign wr_addr = s1_addr;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int k = 0; k < WIN; k++) begin
        window_r[k] <= '0;
      end
    end else if (adv && s1_valid) begin
      for (int k = 0; k < WIN-1; k++) begin
        window_r[k] <= window_r[k+1];
      end
      window_r[WIN-1] <= col;
    end
  end

  // weights are at most 6: small constant products
  always_comb begin
    logic [PART_W-1:0] acc;
    for (int k = 0; k < WIN; k++) begin
      acc = '0;
      for (int j = 0; j < WIN; j++) begin
        if (s2_ctrl_r.row_mask[j]) begin
          acc = acc + (PART_W'(WEIGHTS[j][k]) * PART_W'(window_r[k][j]));
        end
      end
      part[k] = s2_ctrl_r.col_mask[k] ? acc : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid && s1_ctrl.emit;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctrl_r <= s1_ctrl;
      s3_last_r <= s2_ctrl_r.last;
      s3_part_r <= part;
    end
  end

endmodule

>>> hw/rtl/wmf_mean.sv
// ----------------------------------------------------------------------------
// wmf_mean - final sum, divide by 74 and output register
// Adds the column sums, divides by reciprocal multiply and holds the
// result for the output channel.
// ----------------------------------------------------------------------------
module wmf_mean import wmf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             s3_valid,
  input  logic             s3_last,
  input  partials_t        s3_part,
  wmf_out_if.source        out_ch
);

  localparam int PROD_W = SUM_W + DIV_MULT_W;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  s4_sum_r;
  logic              s4_valid_r;
  logic              s4_last_r;
  logic [PROD_W-1:0] prod;
  logic              out_valid_r;
  pixel_t            filtered_r;
  logic              last_r;

  always_comb begin
    sum = '0;
    for (int k = 0; k < WIN; k++) begin
      sum = sum + SUM_W'(s3_part[k]);
    end
  end

  assign prod = PROD_W'(s4_sum_r) * PROD_W'(DIV_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r  <= s3_valid;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sum_r   <= sum;
      s4_last_r  <= s3_last;
      filtered_r <= prod[DIV_SHIFT +: PIX_W];
      last_r     <= s4_last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.filtered      = filtered_r;
  assign out_ch.last_of_frame = last_r;

endmodule

>>> test/wmf_checker.sv
// ----------------------------------------------------------------------------
// wmf_checker - output checker for the weighted 5x5 mean filter
// Follows the configuration port and the input channel, keeps its own copy of
// the line stores, the window and the position counters, and compares every
// output transaction against the oldest predicted filtered pixel.
// ----------------------------------------------------------------------------
module wmf_checker import wmf_pkg::*; #(
  parameter int MAX_W = DEF_MAX_WIDTH,
  parameter int MAX_H = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  wmf_in_if                    in_ch,
  wmf_out_if                   out_ch,
  output int                   err_cnt,
  output int                   pending_cnt
);

  typedef struct packed {
    pixel_t filtered;
    logic   last;
  } out_pixel_t;

  // weight[row][column]
  localparam int KERNEL [WIN][WIN] = '{
    '{1, 2, 3, 2, 1},
    '{2, 4, 5, 4, 2},
    '{3, 5, 6, 5, 3},
    '{2, 4, 5, 4, 2},
    '{1, 2, 3, 2, 1}
  };

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  pixel_t           line_mem [LINES][MAX_W];
  pixel_t           win [WIN][WIN];          // [column age, oldest first][row]
  int unsigned      in_col, in_row, out_col, out_row;
  out_pixel_t       expected_pixels [$];

  initial err_cnt = 0;
  initial pending_cnt = 0;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_frame();
    foreach (win[k, j]) win[k][j] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endtask

  // One input transaction through the window; emits is set when it yields
  // an output pixel.
  task automatic window_mean_step(input logic op, input pixel_t px,
                                  output bit emits, output out_pixel_t res);
    int unsigned w, h, ic, sum, c, r;
    pixel_t      col [WIN];
    pixel_t      nv;
    bit          emit_now;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    emits = 1'b0;
    res = '0;
    // a drain while pixels are still due is dropped
    if (!(in_row < h && op == OP_DRAIN)) begin
      nv = (in_row < h) ? px : '0;
      ic = (in_col >= w) ? 0 : in_col;
      for (int j = 0; j < LINES; j++) col[j] = line_mem[j][ic];
      col[LINES] = nv;
      for (int j = 0; j < LINES; j++) line_mem[j][ic] = col[j+1];
      for (int k = 0; k < WIN - 1; k++) win[k] = win[k+1];
      win[WIN-1] = col;
      emit_now = (in_row > 2) || (in_row == 2 && ic >= 2);
      in_col = ic + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (emit_now) begin
        sum = 0;
        for (int k = 0; k < WIN; k++) begin
          c = out_col + k;
          if (c >= HALF && c - HALF < w) begin
            for (int j = 0; j < WIN; j++) begin
              r = out_row + j;
              if (r >= HALF && r - HALF < h) sum += KERNEL[j][k] * win[k][j];
            end
          end
        end
        res.filtered = pixel_t'(sum / WEIGHT_SUM);
        res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
        emits = 1'b1;
        if (res.last) begin
          in_col = 0;
          in_row = 0;
          out_col = 0;
          out_row = 0;
        end else begin
          out_col++;
          if (out_col >= w) begin
            out_col = 0;
            out_row++;
          end
        end
      end
    end
  endtask

  task automatic flag_error(input string what, input out_pixel_t want, input out_pixel_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("ERROR %0t: %s: expected filtered=%0d last=%0b, got filtered=%0d last=%0b",
               $realtime, what, want.filtered, want.last, got.filtered, got.last);
  endtask

  always @(posedge clk) begin : monitor
    bit         got_pixel;
    out_pixel_t next_pixel, want, seen;
    if (!rst_n) begin
      width_reg = RESET_DIM;
      height_reg = RESET_DIM;
      restart_frame();
      expected_pixels.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.filtered = out_ch.filtered;
        seen.last = out_ch.last_of_frame;
        if (expected_pixels.size() == 0) begin
          flag_error("output with nothing expected", '0, seen);
        end else begin
          want = expected_pixels.pop_front();
          if (seen.filtered !== want.filtered || seen.last !== want.last)
            flag_error("output mismatch", want, seen);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        window_mean_step(in_ch.opcode, in_ch.pixel, got_pixel, next_pixel);
        if (got_pixel) expected_pixels.push_back(next_pixel);
      end
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_wdata;
          restart_frame();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_wdata;
          restart_frame();
        end
      end
    end
    pending_cnt = expected_pixels.size();
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for weighted_mean_filter_5x5_unit
// Streams frames of grey pixels with bursty input and a stalling output,
// changes the frame size between frames, and lets wmf_checker predict and
// compare every filtered pixel.
// ----------------------------------------------------------------------------
module tb_top import wmf_pkg::*; ();

  localparam int DRAIN_WAIT    = 16;        // cycles past the last result before a cfg write
  localparam int TARGET_PIXELS = 500;       // pixel transactions in the random part
  localparam int RUN_LIMIT     = 2_000_000; // time units

  typedef enum int {
    PAT_RANDOM,
    PAT_WHITE,
    PAT_BLACK,
    PAT_CHECKER,
    PAT_DIM
  } pattern_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   err_cnt;
  int                   pending_cnt;

  // frame size the block is using, after clamping
  int unsigned frame_w, frame_h;
  int          burst_left;
  int          hold_len;       // set by the stimulus, consumed by the receiver
  int          pixels_sent;
  bit          force_cfg;
  pattern_t    pat;

  wmf_in_if  in_ch ();
  wmf_out_if out_ch ();

  weighted_mean_filter_5x5_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  wmf_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .err_cnt    (err_cnt),
    .pending_cnt(pending_cnt)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the block hangs or results never arrive.
  initial begin
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned effective_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pixel_t make_pixel(input pattern_t p);
    case (p)
      PAT_WHITE:   return 8'hFF;
      PAT_BLACK:   return 8'h00;
      PAT_CHECKER: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PAT_DIM:     return pixel_t'($urandom_range(0, 7));
      default:     return pixel_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim(input int unsigned hi);
    // mostly legal sizes, sometimes below the minimum
    if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(0, MIN_DIM - 1));
    return CFG_W'($urandom_range(MIN_DIM, hi));
  endfunction

  // Offer one transaction and hold it until the block takes it. Inputs move at
  // the falling edge; valid stays high into the next call so back-to-back
  // transactions never drop valid within a step.
  task automatic send_item(input opcode_t op, input pixel_t px);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.pixel = px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering, wait for every predicted pixel, then let the pipeline empty
  // of transactions that produce no output.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Only called once the block is idle (after reset or settle).
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    if (idx == REG_FRAME_WIDTH) frame_w = effective_dim(v, DEF_MAX_WIDTH);
    else frame_h = effective_dim(v, DEF_MAX_HEIGHT);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Send n_pix pixels with stray drains mixed in (those are dropped by the
  // block). A complete frame is then flushed by 2W+2 items, each a drain or a
  // surplus pixel that the block treats as a drain. hold_at >= 0 asks the
  // receiver for a long stall at that pixel.
  task automatic run_frame(input int unsigned n_pix, input bit complete,
                           input pattern_t p, input int hold_at);
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(OP_DRAIN, pixel_t'($urandom));
      if (i == hold_at) hold_len = $urandom_range(300, 500);
      send_item(OP_PIXEL, make_pixel(p));
      pixels_sent++;
    end
    if (complete) begin
      for (int i = 0; i < 2 * frame_w + 2; i++) begin
        if ($urandom_range(0, 1)) send_item(OP_DRAIN, pixel_t'($urandom));
        else send_item(OP_PIXEL, pixel_t'($urandom));
      end
    end
  endtask

  // Output side: stall behavior changes from segment to segment, from always
  // ready to mostly stalled. A long hold from the stimulus wins over all.
  initial begin : receiver
    int mode, seg_left, phase;
    out_ch.ready = 1'b0;
    seg_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_len - 1) @(negedge clk);
        hold_len = 0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 80);
        end
        seg_left--;
        phase++;
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = $urandom_range(0, 1);
          2:       out_ch.ready = ($urandom_range(0, 7) == 0);
          default: out_ch.ready = (phase % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_PIXEL;
    in_ch.pixel = '0;
    frame_w = RESET_DIM;
    frame_h = RESET_DIM;
    burst_left = 0;
    hold_len = 0;
    pixels_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wide frame first. The receiver stalls for a long time once output is
    // flowing, so the block has to backpressure its input.
    write_reg(REG_FRAME_WIDTH, 10'd40);
    write_reg(REG_FRAME_HEIGHT, 10'd6);
    run_frame(40 * 6, 1'b1, PAT_RANDOM, 2 * 40 + 20);
    settle();

    // Smallest frame via sizes below the minimum, all-white, a drain at the
    // frame start and another after the flagged output (both dropped).
    write_reg(REG_FRAME_WIDTH, 10'd0);
    write_reg(REG_FRAME_HEIGHT, 10'd2);
    send_item(OP_DRAIN, 8'hFF);
    run_frame(9, 1'b1, PAT_WHITE, -1);
    send_item(OP_DRAIN, 8'h00);
    settle();

    // Width above the maximum, frame left unfinished; the next write restarts it.
    write_reg(REG_FRAME_WIDTH, 10'h3FF);
    write_reg(REG_FRAME_HEIGHT, 10'd3);
    run_frame(4, 1'b0, PAT_RANDOM, -1);
    settle();

    // Narrowest frame, taller than the window, with a second long output stall.
    write_reg(REG_FRAME_WIDTH, 10'd1);
    write_reg(REG_FRAME_HEIGHT, 10'd40);
    run_frame(3 * 40, 1'b1, PAT_RANDOM, 100);

    // Random frames: mostly complete, sometimes abandoned mid-way, sizes
    // changed between frames, otherwise frames run back to back.
    pixels_sent = 0;
    force_cfg = 1'b1;
    while (pixels_sent < TARGET_PIXELS) begin
      if (force_cfg || $urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 2))
          0: write_reg(REG_FRAME_WIDTH, rand_dim(40));
          1: write_reg(REG_FRAME_HEIGHT, rand_dim(12));
          default: begin
            write_reg(REG_FRAME_WIDTH, rand_dim(40));
            write_reg(REG_FRAME_HEIGHT, rand_dim(12));
          end
        endcase
        force_cfg = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        settle();
      end
      pat = pattern_t'($urandom_range(0, 4));
      if ($urandom_range(0, 9) == 0) begin
        run_frame($urandom_range(1, frame_w * frame_h - 1), 1'b0, pat, -1);
        force_cfg = 1'b1;
      end else begin
        run_frame(frame_w * frame_h, 1'b1, pat, -1);
      end
    end

    settle();
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/wmf_pkg.sv
hw/rtl/wmf_in_if.sv
hw/rtl/wmf_out_if.sv
hw/rtl/wmf_ram.sv
hw/rtl/wmf_ctrl.sv
hw/rtl/wmf_window.sv
hw/rtl/wmf_mean.sv
hw/rtl/weighted_mean_filter_5x5_unit.sv
test/wmf_checker.sv
test/tb_top.sv
